// ----- src/cgpt_pkg.sv -----
// Shared types and constants for the ghost page table with CLOCK replacement.
package cgpt_pkg;

    // Field widths of one record and of the stream beats
    localparam int OFFSET_W = 48;
    localparam int HITS_W   = 16;
    localparam int KIND_W   = 2;
    localparam int REC_W    = OFFSET_W + HITS_W + 1;
    localparam int TDATA_W  = ((REC_W + 7) / 8) * 8;

    // Item kinds carried on the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_HALVE  = 2'd2
    } kind_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HALVE,
        ST_SWEEP
    } state_t;

    // One stored record; offset sits in the lowest bits
    typedef struct packed {
        logic              referenced;
        logic [HITS_W-1:0] hits;
        logic [OFFSET_W-1:0] offset;
    } rec_t;

endpackage

// ----- src/cgpt_store.sv -----
// Record memory: one write port, one read port with registered read data.
module cgpt_store #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output cgpt_pkg::rec_t       rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  cgpt_pkg::rec_t       wr_data
);
    import cgpt_pkg::*;

    rec_t mem [ENTRIES];
    rec_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/clock_ghost_page_table_core.sv -----
// Ghost page table core: controller, record store and result register.
//
// A table of TABLE_ENTRIES records (offset, hit count, referenced bit) held in one
// synchronous RAM, scanned one entry per cycle through its single read port. An insert
// into a table that is not full appends at the fill point. An insert into a full table
// runs the CLOCK hand: each referenced record passed has its bit cleared, and the first
// unreferenced record is replaced. A search examines records in order up to the first
// match, waits while a previous result is stalled in the output register, and returns
// one beat (hit or miss). A halve shifts the hit count of every filled record right.
// A new item is taken only when the previous one is finished; a search result may
// wait in the output register while the next item is already being worked on.
// The table needs no clearing after reset: only filled records are ever read.
module clock_ghost_page_table_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cgpt_pkg::TDATA_W-1:0]  s_axis_tdata,  // page_offset, page_hits, page_referenced
    input  logic [cgpt_pkg::KIND_W-1:0]   s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cgpt_pkg::TDATA_W-1:0]  m_axis_tdata,  // found_offset, found_hits, found_referenced
    output logic                          m_axis_tuser   // found
);
    import cgpt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] TOP_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] filled_reg, filled_next;
    logic [IDX_W-1:0] hand_reg, hand_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    rec_t             item_reg, item_next;
    logic             out_valid_reg;
    logic             out_found_reg;
    rec_t             out_rec_reg;

    logic             s_acc;
    kind_t            in_kind;
    rec_t             in_rec;
    logic             full;
    logic [IDX_W-1:0] hand_adv;
    logic             result_ok;
    logic             match;
    logic             scan_end;
    logic             result_set;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    rec_t             rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;

    cgpt_store #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Handshake and decode
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign in_kind       = kind_t'(s_axis_tuser);
    assign in_rec        = rec_t'(s_axis_tdata[REC_W-1:0]);
    assign full          = (filled_reg == FULL_CNT);
    assign hand_adv      = (hand_reg == TOP_IDX) ? '0 : hand_reg + 1'b1;
    assign result_ok     = !out_valid_reg || m_axis_tready;
    assign match         = pend_reg && (rd_data.offset == item_reg.offset);
    assign scan_end      = (idx_reg >= filled_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    case (in_kind)
                        KIND_INSERT: state_next = full ? ST_SWEEP : ST_IDLE;
                        KIND_SEARCH: state_next = ST_SEARCH;
                        KIND_HALVE:  state_next = ST_HALVE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if ((match || scan_end) && result_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HALVE:
            begin
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (!rd_data.referenced)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory accesses and scan bookkeeping
    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = idx_reg[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = pidx_reg;
        wr_data     = rd_data;
        filled_next = filled_reg;
        hand_next   = hand_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        pidx_next   = idx_reg[IDX_W-1:0];
        item_next   = item_reg;
        result_set  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    item_next = in_rec;
                    idx_next  = '0;
                    if (in_kind == KIND_INSERT)
                    begin
                        if (!full)
                        begin
                            // append at the fill point
                            wr_en       = 1'b1;
                            wr_addr     = filled_reg[IDX_W-1:0];
                            wr_data     = in_rec;
                            filled_next = filled_reg + 1'b1;
                        end
                        else
                        begin
                            // start the hand on the next record
                            rd_en     = 1'b1;
                            rd_addr   = hand_adv;
                            hand_next = hand_adv;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                if (match || scan_end)
                begin
                    if (result_ok)
                    begin
                        result_set = 1'b1;
                        if (match)
                        begin
                            wr_en              = 1'b1;
                            wr_data.referenced = 1'b1;
                        end
                    end
                    else
                    begin
                        // result register busy: hold the pending read
                        pend_next = pend_reg;
                        pidx_next = pidx_reg;
                    end
                end
                else
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            ST_HALVE:
            begin
                if (pend_reg)
                begin
                    wr_en        = 1'b1;
                    wr_data.hits = rd_data.hits >> 1;
                end
                if (!scan_end)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            ST_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = hand_reg;
                if (rd_data.referenced)
                begin
                    // second chance: clear and move on
                    wr_data.referenced = 1'b0;
                    rd_en              = 1'b1;
                    rd_addr            = hand_adv;
                    hand_next          = hand_adv;
                end
                else
                begin
                    wr_data = item_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filled_reg    <= '0;
            hand_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            hand_reg   <= hand_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            if (result_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        item_reg <= item_next;
        if (result_set)
        begin
            out_found_reg <= match;
            out_rec_reg   <= match ? rd_data : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {(TDATA_W - REC_W)'(0), out_rec_reg};

endmodule

// ----- src/cgpt_checker.sv -----
// Port-level checks for the ghost page table core, bound to the top level.
module cgpt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [cgpt_pkg::KIND_W-1:0]   s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [cgpt_pkg::TDATA_W-1:0]  m_axis_tdata,
    input logic                          m_axis_tuser
);
    import cgpt_pkg::*;

    // A search keeps the controller busy in the cycle after it is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (kind_t'(s_axis_tuser) == KIND_SEARCH)
        |=> !s_axis_tready)
    else $error("search accepted without busy cycle");

    // A new result only follows search work, during which the input is not ready
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without search work");

    // A miss carries an all-zero record
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("miss with nonzero payload");

    // A stalled result beat stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

    // A stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

endmodule

bind clock_ghost_page_table_core cgpt_checker u_cgpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
